>>> sv/gamepad_edge_and_stick_normalizer_unit_assert.svh
// Assertion macros for the gamepad normalizer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef GAMEPAD_EDGE_AND_STICK_NORMALIZER_UNIT_ASSERT_SVH
`define GAMEPAD_EDGE_AND_STICK_NORMALIZER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define GESN_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gesn assertion failed");
`define GESN_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("gesn assertion failed");
`else
`define GESN_ASSERT(lbl, clk, rst, prop)
`define GESN_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> sv/gesn_pkg.sv
// Shared types and constants for the gamepad edge and stick normalizer.
// No dependencies.
`default_nettype none
package gesn_pkg;

   localparam int NUM_BUTTONS_DEFAULT = 12;

   localparam logic [1:0] KIND_PRESS   = 2'd0;
   localparam logic [1:0] KIND_RELEASE = 2'd1;
   localparam logic [1:0] KIND_AXIS    = 2'd2;

   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;

   localparam logic [7:0]  CENTRE_RESET = 8'd128;
   localparam logic [7:0]  POS_FULL     = 8'd255;
   localparam logic [15:0] Q15_MAX      = 16'd32767;
   localparam int          DIV_STEPS    = 16;
   localparam int          STEP_W       = $clog2(DIV_STEPS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIVIDE
   } state_type;

   typedef struct packed {
      logic capture;
      logic scan_step;
      logic div_start;
      logic div_axis;
      logic div_step;
      logic emit_axis;
   } cmd_type;

   typedef struct packed {
      logic diff_bit;
      logic scan_last;
      logic x_changed;
      logic y_changed;
      logic div_done;
      logic div_axis;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

>>> sv/gesn_datapath.sv
// Datapath: held button state, stick calibration, serial Q1.15 divider
// and the result register. Depends on gesn_pkg.
`default_nettype none
module gesn_datapath #(
   parameter int NUM_BUTTONS = gesn_pkg::NUM_BUTTONS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [NUM_BUTTONS-1:0] req_button_bits,
   input  wire logic [7:0]             req_stick_x,
   input  wire logic [7:0]             req_stick_y,
   input  wire gesn_pkg::cmd_type      cmd,
   output gesn_pkg::status_type        status,
   input  wire logic                   rsp_ready,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_event_kind,
   output logic [3:0]                  rsp_button_index,
   output logic                        rsp_axis_select,
   output logic signed [15:0]          rsp_axis_value,
   output logic                        rsp_last_event
);

   localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

   // persistent state
   logic [NUM_BUTTONS-1:0] held_ff, held_in;
   logic                   calibrated_ff, calibrated_in;
   logic [7:0]             centre_x_ff, centre_x_in;
   logic [7:0]             centre_y_ff, centre_y_in;
   logic [7:0]             prior_x_ff, prior_x_in;
   logic [7:0]             prior_y_ff, prior_y_in;

   // per-poll work registers
   logic [NUM_BUTTONS-1:0] diff_ff, diff_in;
   logic [NUM_BUTTONS-1:0] now_ff, now_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   xch_ff, xch_in;
   logic                   ych_ff, ych_in;

   // divider
   logic [8:0]                  rem_ff, rem_in;
   logic [15:0]                 quo_ff, quo_in;
   logic [gesn_pkg::STEP_W-1:0] step_ff, step_in;
   logic [7:0]                  range_ff, range_in;
   logic                        neg_ff, neg_in;
   logic                        axis_ff, axis_in;

   // result register
   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [3:0]  bidx_ff, bidx_in;
   logic        asel_ff, asel_in;
   logic [15:0] value_ff, value_in;
   logic        last_ff, last_in;

   logic                   out_free;
   logic                   diff_bit;
   logic [NUM_BUTTONS-1:0] idx_mask;
   logic [NUM_BUTTONS-1:0] diff_rest;
   logic [IDX_W+3:0]       idx_wide;
   logic [7:0]             div_pos;
   logic [7:0]             div_ctr;
   logic                   div_ge;
   logic [8:0]             div_diff;
   logic [15:0]            q_sat;
   logic [15:0]            q_signed;

   assign out_free  = !valid_ff || rsp_ready;
   assign diff_bit  = diff_ff[idx_ff];
   assign idx_mask  = NUM_BUTTONS'(1) << idx_ff;
   assign diff_rest = diff_ff & ~idx_mask;
   assign idx_wide  = {4'b0000, idx_ff};

   assign div_pos  = cmd.div_axis ? prior_y_ff : prior_x_ff;
   assign div_ctr  = cmd.div_axis ? centre_y_ff : centre_x_ff;
   assign div_ge   = rem_ff >= {1'b0, range_ff};
   assign div_diff = rem_ff - (div_ge ? {1'b0, range_ff} : 9'd0);

   // a quotient of exactly 1.0 clips to the largest Q1.15 value
   assign q_sat    = quo_ff[15] ? gesn_pkg::Q15_MAX : quo_ff;
   assign q_signed = neg_ff ? (16'd0 - q_sat) : q_sat;

   always_comb begin
      held_in       = held_ff;
      calibrated_in = calibrated_ff;
      centre_x_in   = centre_x_ff;
      centre_y_in   = centre_y_ff;
      prior_x_in    = prior_x_ff;
      prior_y_in    = prior_y_ff;
      diff_in       = diff_ff;
      now_in        = now_ff;
      idx_in        = idx_ff;
      xch_in        = xch_ff;
      ych_in        = ych_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      range_in      = range_ff;
      neg_in        = neg_ff;
      axis_in       = axis_ff;
      kind_in       = kind_ff;
      bidx_in       = bidx_ff;
      asel_in       = asel_ff;
      value_in      = value_ff;
      last_in       = last_ff;
      valid_in      = rsp_ready ? 1'b0 : valid_ff;

      if (cmd.capture) begin
         held_in  = req_button_bits;
         diff_in  = req_button_bits ^ held_ff;
         now_in   = req_button_bits;
         idx_in   = '0;
         prior_x_in = req_stick_x;
         prior_y_in = req_stick_y;
         if (!calibrated_ff) begin
            calibrated_in = 1'b1;
            centre_x_in   = req_stick_x;
            centre_y_in   = req_stick_y;
            xch_in        = 1'b0;
            ych_in        = 1'b0;
         end else begin
            xch_in = prior_x_ff != req_stick_x;
            ych_in = prior_y_ff != req_stick_y;
         end
      end

      if (cmd.scan_step) begin
         idx_in = idx_ff + IDX_W'(1);
         if (diff_bit) begin
            diff_in  = diff_rest;
            valid_in = 1'b1;
            kind_in  = now_ff[idx_ff] ? gesn_pkg::KIND_PRESS : gesn_pkg::KIND_RELEASE;
            bidx_in  = idx_wide[3:0];
            asel_in  = gesn_pkg::AXIS_X;
            value_in = 16'd0;
            last_in  = (diff_rest == '0) && !xch_ff && !ych_ff;
         end
      end

      if (cmd.emit_axis) begin
         valid_in = 1'b1;
         kind_in  = gesn_pkg::KIND_AXIS;
         bidx_in  = 4'd0;
         asel_in  = axis_ff;
         value_in = (range_ff == 8'd0) ? 16'd0 : q_signed;
         last_in  = (axis_ff == gesn_pkg::AXIS_Y) || !ych_ff;
      end

      if (cmd.div_step) begin
         rem_in  = {div_diff[7:0], 1'b0};
         quo_in  = {quo_ff[14:0], div_ge};
         step_in = step_ff + gesn_pkg::STEP_W'(1);
      end

      if (cmd.div_start) begin
         axis_in = cmd.div_axis;
         quo_in  = '0;
         step_in = '0;
         if (div_pos >= div_ctr) begin
            rem_in   = {1'b0, div_pos - div_ctr};
            range_in = gesn_pkg::POS_FULL - div_ctr;
            neg_in   = cmd.div_axis;
         end else begin
            rem_in   = {1'b0, div_ctr - div_pos};
            range_in = div_ctr;
            neg_in   = !cmd.div_axis;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= '0;
         calibrated_ff <= 1'b0;
         centre_x_ff   <= gesn_pkg::CENTRE_RESET;
         centre_y_ff   <= gesn_pkg::CENTRE_RESET;
         prior_x_ff    <= gesn_pkg::CENTRE_RESET;
         prior_y_ff    <= gesn_pkg::CENTRE_RESET;
         valid_ff      <= 1'b0;
         step_ff       <= '0;
         idx_ff        <= '0;
      end else begin
         held_ff       <= held_in;
         calibrated_ff <= calibrated_in;
         centre_x_ff   <= centre_x_in;
         centre_y_ff   <= centre_y_in;
         prior_x_ff    <= prior_x_in;
         prior_y_ff    <= prior_y_in;
         valid_ff      <= valid_in;
         step_ff       <= step_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff  <= diff_in;
      now_ff   <= now_in;
      xch_ff   <= xch_in;
      ych_ff   <= ych_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      range_ff <= range_in;
      neg_ff   <= neg_in;
      axis_ff  <= axis_in;
      kind_ff  <= kind_in;
      bidx_ff  <= bidx_in;
      asel_ff  <= asel_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   always_comb begin
      status.diff_bit  = diff_bit;
      status.scan_last = idx_ff == IDX_W'(NUM_BUTTONS - 1);
      status.x_changed = xch_ff;
      status.y_changed = ych_ff;
      status.div_done  = step_ff == gesn_pkg::STEP_W'(gesn_pkg::DIV_STEPS);
      status.div_axis  = axis_ff;
      status.out_free  = out_free;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_event_kind   = kind_ff;
   assign rsp_button_index = bidx_ff;
   assign rsp_axis_select  = asel_ff;
   assign rsp_axis_value   = value_ff;
   assign rsp_last_event   = last_ff;

endmodule
`default_nettype wire

>>> sv/gesn_controller.sv
// Controller: sequences capture, button scan and the two axis divisions.
// Depends on gesn_pkg and the assertion macro header.
`default_nettype none
`include "gamepad_edge_and_stick_normalizer_unit_assert.svh"
module gesn_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire gesn_pkg::status_type status,
   output gesn_pkg::cmd_type         cmd
);

   gesn_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gesn_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         gesn_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = gesn_pkg::ST_SCAN;
            end
         end
         gesn_pkg::ST_SCAN: begin
            // hold the scan while a changed button waits on a full result slot
            if (!status.diff_bit || status.out_free) begin
               cmd.scan_step = 1'b1;
               if (status.scan_last) begin
                  if (status.x_changed) begin
                     cmd.div_start = 1'b1;
                     cmd.div_axis  = gesn_pkg::AXIS_X;
                     state_in      = gesn_pkg::ST_DIVIDE;
                  end else if (status.y_changed) begin
                     cmd.div_start = 1'b1;
                     cmd.div_axis  = gesn_pkg::AXIS_Y;
                     state_in      = gesn_pkg::ST_DIVIDE;
                  end else begin
                     state_in = gesn_pkg::ST_IDLE;
                  end
               end
            end
         end
         gesn_pkg::ST_DIVIDE: begin
            if (!status.div_done) begin
               cmd.div_step = 1'b1;
            end else if (status.out_free) begin
               cmd.emit_axis = 1'b1;
               if (status.div_axis == gesn_pkg::AXIS_X && status.y_changed) begin
                  cmd.div_start = 1'b1;
                  cmd.div_axis  = gesn_pkg::AXIS_Y;
               end else begin
                  state_in = gesn_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = gesn_pkg::ST_IDLE;
         end
      endcase
   end

   `GESN_ASSERT(a_one_poll_at_a_time, clock, reset, (req_valid && req_ready) |=> !req_ready)
   `GESN_ASSERT(a_button_load_has_room, clock, reset,
      (cmd.scan_step && status.diff_bit) |-> status.out_free)
   `GESN_ASSERT(a_axis_emit_after_divide, clock, reset,
      cmd.emit_axis |-> (status.div_done && status.out_free))
   `GESN_ASSERT_ALWAYS(a_no_step_past_done, clock, cmd.div_step |-> !status.div_done)

endmodule
`default_nettype wire

>>> sv/gamepad_edge_and_stick_normalizer_unit.sv
// Sequence: a capture, then a scan over the buttons (NUM_BUTTONS), then
// per changed axis 16 divider steps followed by the result load. A new
// poll is taken once the previous one is fully issued. Result
// backpressure stalls the scan and the axis result loads.
// Synchronous active-high reset: buttons released, uncalibrated,
// centres and previous positions at 128, no result pending.
`default_nettype none
module gamepad_edge_and_stick_normalizer_unit #(
   parameter int NUM_BUTTONS = gesn_pkg::NUM_BUTTONS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [NUM_BUTTONS-1:0] req_button_bits,
   input  wire logic [7:0]             req_stick_x,
   input  wire logic [7:0]             req_stick_y,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [1:0]                  rsp_event_kind,
   output logic [3:0]                  rsp_button_index,
   output logic                        rsp_axis_select,
   output logic signed [15:0]          rsp_axis_value,
   output logic                        rsp_last_event
);

   gesn_pkg::cmd_type    cmd;
   gesn_pkg::status_type status;

   gesn_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gesn_datapath #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_button_bits  (req_button_bits),
      .req_stick_x      (req_stick_x),
      .req_stick_y      (req_stick_y),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_button_index (rsp_button_index),
      .rsp_axis_select  (rsp_axis_select),
      .rsp_axis_value   (rsp_axis_value),
      .rsp_last_event   (rsp_last_event)
   );

endmodule
`default_nettype wire
